### rtl/core/dft_pkg.sv
// ----------------------------------------------------------------------------
// DShot frame transmitter package
// Shared transaction types, action codes and register defaults.
// ----------------------------------------------------------------------------
package dft_pkg;

   // Action codes carried by a request transaction.
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_RAW    = 2'd1;
   localparam logic [1:0] ACT_PLAIN  = 2'd2;
   localparam logic [1:0] ACT_3D     = 2'd3;

   // Control register indexes.
   localparam logic [1:0] CSR_BIT_TICKS  = 2'd0;
   localparam logic [1:0] CSR_ZERO_HIGH  = 2'd1;
   localparam logic [1:0] CSR_ONE_HIGH   = 2'd2;
   localparam logic [1:0] CSR_PAUSE      = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register values after reset.
   localparam logic [7:0]  RST_BIT_TICKS  = 8'd19;
   localparam logic [7:0]  RST_ZERO_HIGH  = 8'd7;
   localparam logic [7:0]  RST_ONE_HIGH   = 8'd14;
   localparam logic [15:0] RST_PAUSE      = 16'd3800;

   // Throttle mapping constants.
   localparam logic [10:0] THR_MIN        = 11'd48;
   localparam logic [10:0] THR_MAX        = 11'd2047;
   localparam logic [10:0] THR_PLAIN_TOP  = 11'd1999;
   localparam logic signed [12:0] THR3D_LIM      = 13'sd999;
   localparam logic signed [12:0] THR3D_NEG_BASE = 13'sd1000;

   localparam logic [4:0]  FRAME_BITS     = 5'd16;

   typedef struct packed {
      logic [1:0]         action;
      logic [10:0]        payload;
      logic               telemetry;
      logic signed [11:0] signed_throttle;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  bit_ticks;
      logic [7:0]  zero_high_ticks;
      logic [7:0]  one_high_ticks;
      logic [15:0] pause_ticks;
   } cfg_type;

endpackage

### rtl/core/dft_stream_if.sv
// ----------------------------------------------------------------------------
// DShot stream channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dft_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/dft_csr_file.sv
// ----------------------------------------------------------------------------
// DShot control registers
// Holds the bit timing and pause registers written through the write port.
// ----------------------------------------------------------------------------
module dft_csr_file
   import dft_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en_i,
   input  logic [CSR_INDEX_W-1:0] index_i,
   input  logic [CSR_DATA_W-1:0]  data_i,
   output cfg_type                cfg_o
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en_i) begin
         case (index_i)
            CSR_BIT_TICKS: cfg_in.bit_ticks       = data_i[7:0];
            CSR_ZERO_HIGH: cfg_in.zero_high_ticks = data_i[7:0];
            CSR_ONE_HIGH:  cfg_in.one_high_ticks  = data_i[7:0];
            CSR_PAUSE:     cfg_in.pause_ticks     = data_i;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks       <= RST_BIT_TICKS;
         cfg_ff.zero_high_ticks <= RST_ZERO_HIGH;
         cfg_ff.one_high_ticks  <= RST_ONE_HIGH;
         cfg_ff.pause_ticks     <= RST_PAUSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

### rtl/core/dft_frame_encoder.sv
// ----------------------------------------------------------------------------
// DShot frame encoder
// Maps the request to an 11-bit value and appends telemetry and checksum.
// ----------------------------------------------------------------------------
module dft_frame_encoder
   import dft_pkg::*;
(
   input  req_type     req_i,
   output logic [15:0] frame_o
);

   logic signed [12:0] st_wide;
   logic signed [12:0] st_clamp;
   logic signed [12:0] st_fold;
   logic [10:0]        thr_amount;
   logic [10:0]        thr_mapped;
   logic [10:0]        value;
   logic               tele;
   logic [11:0]        word;
   logic [3:0]         csum;

   // Clamp the 3D throttle and fold negative values above the forward range.
   always_comb begin
      st_wide  = 13'(req_i.signed_throttle);
      st_clamp = st_wide;
      if (st_wide > THR3D_LIM) begin
         st_clamp = THR3D_LIM;
      end
      if (st_wide < -THR3D_LIM) begin
         st_clamp = -THR3D_LIM;
      end
      st_fold = st_clamp;
      if (st_clamp < 13'sd0) begin
         st_fold = THR3D_NEG_BASE - st_clamp;
      end
   end

   // Plain mapping shared by both throttle kinds, saturating at the top.
   always_comb begin
      if (req_i.action == ACT_3D) begin
         thr_amount = st_fold[10:0];
      end else begin
         thr_amount = req_i.payload;
      end
      if (thr_amount > THR_PLAIN_TOP) begin
         thr_mapped = THR_MAX;
      end else begin
         thr_mapped = thr_amount + THR_MIN;
      end
   end

   // Select the value and telemetry bit, then form the nibble checksum.
   always_comb begin
      if (req_i.action == ACT_RAW) begin
         value = req_i.payload;
         tele  = req_i.telemetry;
      end else begin
         value = thr_mapped;
         tele  = 1'b0;
      end
      word    = {value, tele};
      csum    = word[3:0] ^ word[7:4] ^ word[11:8];
      frame_o = {word, csum};
   end

endmodule

### rtl/core/dft_wave_engine.sv
// ----------------------------------------------------------------------------
// DShot waveform engine
// Advances the frame shifter, bit timer and pause timer by one tick per step.
// ----------------------------------------------------------------------------
module dft_wave_engine
   import dft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_i,
   input  logic [1:0]  action_i,
   input  logic [15:0] frame_i,
   input  cfg_type     cfg_i,
   output rsp_type     rsp_o
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_BITS  = 2'd1;
   localparam logic [1:0] PH_PAUSE = 2'd2;

   logic [15:0] shift_ff,  shift_in;
   logic [4:0]  bits_ff,   bits_in;
   logic [15:0] tick_ff,   tick_in;
   logic [1:0]  phase_ff,  phase_in;

   logic        load;
   logic        busy_now;
   logic        take_load;
   logic        drop_load;
   logic [15:0] eff_shift;
   logic [4:0]  eff_bits;
   logic [15:0] eff_tick;
   logic [1:0]  eff_phase;
   logic [15:0] tick_inc;
   logic [4:0]  bits_dec;
   logic [7:0]  high_ticks;

   // A load starts a frame only from idle; otherwise it is dropped.
   always_comb begin
      load      = (action_i != ACT_TICK);
      busy_now  = (phase_ff == PH_BITS) || (phase_ff == PH_PAUSE);
      drop_load = load && busy_now;
      take_load = load && !busy_now;
      eff_shift = shift_ff;
      eff_bits  = bits_ff;
      eff_tick  = tick_ff;
      eff_phase = phase_ff;
      if (take_load) begin
         eff_shift = frame_i;
         eff_bits  = FRAME_BITS;
         eff_tick  = 16'd0;
         eff_phase = PH_BITS;
      end
   end

   // Drive this tick of the waveform and work out the next state.
   always_comb begin
      tick_inc   = eff_tick + 16'd1;
      bits_dec   = eff_bits - 5'd1;
      high_ticks = eff_shift[15] ? cfg_i.one_high_ticks : cfg_i.zero_high_ticks;
      shift_in   = eff_shift;
      bits_in    = eff_bits;
      tick_in    = eff_tick;
      phase_in   = PH_IDLE;
      rsp_o.line_level = 1'b0;
      rsp_o.busy_res   = 1'b0;
      rsp_o.accepted   = take_load;
      rsp_o.rejected   = drop_load;
      case (eff_phase)
         PH_BITS: begin
            rsp_o.busy_res   = 1'b1;
            rsp_o.line_level = (eff_tick < {8'd0, high_ticks});
            tick_in  = tick_inc;
            phase_in = PH_BITS;
            if (tick_inc >= {8'd0, cfg_i.bit_ticks}) begin
               tick_in  = 16'd0;
               shift_in = {eff_shift[14:0], 1'b0};
               bits_in  = bits_dec;
               if (bits_dec == 5'd0) begin
                  phase_in = (cfg_i.pause_ticks == 16'd0) ? PH_IDLE : PH_PAUSE;
               end
            end
         end
         PH_PAUSE: begin
            rsp_o.busy_res = 1'b1;
            tick_in  = tick_inc;
            phase_in = PH_PAUSE;
            if (tick_inc >= cfg_i.pause_ticks) begin
               tick_in  = 16'd0;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 16'd0;
         bits_ff  <= 5'd0;
         tick_ff  <= 16'd0;
         phase_ff <= PH_IDLE;
      end else if (step_i) begin
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         tick_ff  <= tick_in;
         phase_ff <= phase_in;
      end
   end

endmodule

### rtl/core/dshot_frame_transmitter_unit.sv
// ----------------------------------------------------------------------------
// DShot frame transmitter
// Builds DShot frames and produces the line waveform one tick per transaction.
// ----------------------------------------------------------------------------
// Every request transaction is one tick of the bit clock and yields exactly one
// response transaction with the line level for that tick. A load request (raw
// value, plain throttle or 3D throttle) starts a frame in the same tick when
// the transmitter is idle and is dropped and flagged when it is busy. The unit
// takes one request per clock cycle while the response channel is not stalled.
// A taken request is held in the input register, passes through the frame
// encoder and waveform engine into the response register, and its response is
// offered from there. A stalled response holds the input register, which then
// holds off the request channel. The timing registers should be written only
// while the transmitter is idle.
module dshot_frame_transmitter_unit
   import dft_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   dft_stream_if.sink             req_bus,
   dft_stream_if.source           rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   req_type     req_ff;
   logic        req_valid_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   logic        advance;
   cfg_type     cfg;
   logic [15:0] frame;
   rsp_type     rsp_next;

   // The held request moves on whenever the response register is free.
   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_ff <= req_bus.data;
      end
   end

   dft_csr_file u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en_i (csr_wr_en),
      .index_i (csr_index),
      .data_i  (csr_data),
      .cfg_o   (cfg)
   );

   dft_frame_encoder u_encoder (
      .req_i   (req_ff),
      .frame_o (frame)
   );

   dft_wave_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step_i   (advance),
      .action_i (req_ff.action),
      .frame_i  (frame),
      .cfg_i    (cfg),
      .rsp_o    (rsp_next)
   );

   // Response register holds each result until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

endmodule
